// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker module of the chunk parser
// expects signals clk and rst_n (active low) in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define PCSP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcsp assertion failed");

// next-cycle implication, quiet during reset
`define PCSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcsp assertion failed");

`endif

// ===== rtl/pcsp_pkg.sv =====
// types and constants of the png chunk stream parser
// no dependencies; imported by the top level, size unit, parse core and checker
`default_nettype none

package pcsp_pkg;

    // parse phases, one-hot
    typedef enum logic [7:0] {
        PH_SIG  = 8'b0000_0001,
        PH_LEN  = 8'b0000_0010,
        PH_TYPE = 8'b0000_0100,
        PH_HDR  = 8'b0000_1000,
        PH_DATA = 8'b0001_0000,
        PH_SKIP = 8'b0010_0000,
        PH_CRC  = 8'b0100_0000,
        PH_DONE = 8'b1000_0000
    } phase_t;

    // parse status codes as they appear on the result word
    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_BADSIG    = 3'd1,
        ST_BADHDR    = 3'd2,
        ST_EARLYDATA = 3'd3,
        ST_TRUNC     = 3'd4,
        ST_DONE      = 3'd5
    } status_t;

    localparam logic [31:0] HDR_LEN    = 32'd13;
    localparam logic [7:0]  COLOUR_BIT = 8'h02;
    localparam logic [7:0]  ALPHA_BIT  = 8'h04;
    localparam logic [31:0] KIND_IHDR  = 32'h4948_4452;
    localparam logic [31:0] KIND_IDAT  = 32'h4944_4154;
    localparam logic [31:0] KIND_IEND  = 32'h4945_4E44;
    localparam logic [2:0]  MAX_CHANNELS = 3'd4;

    // input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic [2:0]  status;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [2:0]  channel_count;
        logic [63:0] raw_size;
    } out_word_t;

    // header fields handed from the parse core to the size unit
    typedef struct packed {
        logic [31:0] width;
        logic [31:0] height;
        logic [2:0]  channels;
    } hdr_info_t;

    // png file signature
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'd137;
            3'd1:    val = 8'd80;
            3'd2:    val = 8'd78;
            3'd3:    val = 8'd71;
            3'd4:    val = 8'd13;
            3'd5:    val = 8'd10;
            3'd6:    val = 8'd26;
            3'd7:    val = 8'd10;
            default: val = 8'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pcsp_stream_if.sv =====
// valid/ready stream channel carrying one word of a chosen payload type
// no dependencies; payload types come from pcsp_pkg at the instance
`default_nettype none

interface pcsp_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== rtl/png_chunk_stream_parser.sv =====
// top level of the png chunk stream parser
// depends on pcsp_pkg, pcsp_stream_if, pcsp_parse_core, pcsp_size_unit
`default_nettype none

// Takes a png file one byte per word on in_s and returns exactly one result
// word on out_s for every byte. Throughput is one byte per clock while out_s
// is ready; each byte passes an input register, then the phase machine into
// the result register. The signature is checked, chunk lengths and types are
// read big-endian, IHDR gives width, height and channel count, IDAT payload
// bytes come out with payload_valid set, other chunks and all crc bytes are
// skipped, and IEND ends the parse with status complete. Any nonzero status
// is sticky: later bytes are taken and answered but change nothing. A byte
// flagged last_byte that leaves the parse busy turns the status to truncated.
// raw_size is height * width * channels, clamped at all ones, formed by a
// two-stage multiplier that runs continuously off the header registers; the
// last header field (the colour byte) is taken fifteen bytes before any IEND
// type can complete, time enough for both stages of the product, so it is
// always ready in time. No clearing pass after reset.
module png_chunk_stream_parser (
    input wire logic     clk,
    input wire logic     rst_n,
    pcsp_stream_if.sink   in_s,
    pcsp_stream_if.source out_s
);

    import pcsp_pkg::*;

    // input register
    in_word_t  stage_reg;
    logic      stage_valid_reg;
    // result register
    out_word_t out_reg;
    logic      out_valid_reg;

    logic       stage_go;
    logic       in_fire;
    out_word_t  result;
    hdr_info_t  hdr;
    logic [63:0] size_value;

    // the stage moves on when the result register is free or being emptied
    assign stage_go  = stage_valid_reg && (!out_valid_reg || out_s.ready);
    assign in_s.ready = !stage_valid_reg || stage_go;
    assign in_fire   = in_s.valid && in_s.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (in_fire)
            stage_valid_reg <= 1'b1;
        else if (stage_go)
            stage_valid_reg <= 1'b0;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
            stage_reg <= in_s.payload;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stage_go)
            out_valid_reg <= 1'b1;
        else if (out_s.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stage_go)
            out_reg <= result;
    end

    // phase machine and header registers
    pcsp_parse_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_fire  (stage_go),
        .item       (stage_reg),
        .size_value (size_value),
        .result     (result),
        .hdr        (hdr)
    );

    // sample count from the header registers
    pcsp_size_unit u_size (
        .clk      (clk),
        .rst_n    (rst_n),
        .hdr      (hdr),
        .raw_size (size_value)
    );

    assign out_s.valid   = out_valid_reg;
    assign out_s.payload = out_reg;

endmodule

`default_nettype wire

// ===== rtl/pcsp_size_unit.sv =====
// two-stage saturating product height * width * channels
// depends on pcsp_pkg
`default_nettype none

module pcsp_size_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pcsp_pkg::hdr_info_t hdr,
    output logic [63:0]              raw_size
);

    import pcsp_pkg::*;

    logic [63:0] prod_reg;
    logic [63:0] prod_next;
    logic [2:0]  chan_reg;
    logic [63:0] size_reg;
    logic [63:0] size_next;
    logic [66:0] scaled;

    // stage 1: 32x32 product
    assign prod_next = 64'(hdr.width) * 64'(hdr.height);

    // stage 2: times channels, clamp on overflow
    assign scaled    = {3'b000, prod_reg} * {64'd0, chan_reg};
    assign size_next = (|scaled[66:64]) ? {64{1'b1}} : scaled[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            chan_reg <= '0;
            size_reg <= '0;
        end
        else
        begin
            prod_reg <= prod_next;
            chan_reg <= hdr.channels;
            size_reg <= size_next;
        end
    end

    assign raw_size = size_reg;

endmodule

`default_nettype wire

// ===== rtl/pcsp_parse_core.sv =====
// chunk phase machine: signature, length, type, header, payload, crc
// depends on pcsp_pkg
`default_nettype none

module pcsp_parse_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_fire,
    input  wire pcsp_pkg::in_word_t  item,
    input  wire logic [63:0]         size_value,
    output pcsp_pkg::out_word_t      result,
    output pcsp_pkg::hdr_info_t      hdr
);

    import pcsp_pkg::*;

    phase_t      phase_reg,  phase_next;
    status_t     status_reg, status_next;
    logic [31:0] pos_reg,    pos_next;
    logic [31:0] len_reg,    len_next;
    logic [31:0] kind_reg,   kind_next;
    logic [31:0] width_reg,  width_next;
    logic [31:0] height_reg, height_next;
    logic [2:0]  chan_reg,   chan_next;
    logic        seen_reg,   seen_next;

    logic [7:0]  b;
    logic [31:0] pos_inc;
    logic [31:0] kind_shift;
    logic [7:0]  pay;
    logic        pvalid;

    assign b          = item.data_byte;
    assign pos_inc    = pos_reg + 32'd1;
    assign kind_shift = {kind_reg[23:0], b};

    always_comb
    begin
        phase_next  = phase_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        kind_next   = kind_reg;
        width_next  = width_reg;
        height_next = height_reg;
        chan_next   = chan_reg;
        seen_next   = seen_reg;
        pay         = 8'd0;
        pvalid      = 1'b0;

        if (status_reg == ST_BUSY)
        begin
            case (phase_reg)
                PH_SIG:
                begin
                    if (b != sig_byte(pos_reg[2:0]))
                        status_next = ST_BADSIG;
                    else if (pos_reg[2:0] == 3'd7)
                    begin
                        phase_next = PH_LEN;
                        pos_next   = '0;
                    end
                    else
                        pos_next = pos_inc;
                end
                PH_LEN:
                begin
                    len_next = {len_reg[23:0], b};
                    if (pos_reg[1:0] == 2'd3)
                    begin
                        phase_next = PH_TYPE;
                        pos_next   = '0;
                    end
                    else
                        pos_next = pos_inc;
                end
                PH_TYPE:
                begin
                    kind_next = kind_shift;
                    if (pos_reg[1:0] == 2'd3)
                    begin
                        pos_next = '0;
                        if (kind_shift == KIND_IHDR)
                        begin
                            if (seen_reg || len_reg != HDR_LEN)
                                status_next = ST_BADHDR;
                            else
                                phase_next = PH_HDR;
                        end
                        else if (kind_shift == KIND_IDAT)
                        begin
                            if (!seen_reg)
                                status_next = ST_EARLYDATA;
                            else
                                phase_next = (len_reg != '0) ? PH_DATA : PH_CRC;
                        end
                        else if (kind_shift == KIND_IEND)
                        begin
                            status_next = ST_DONE;
                            phase_next  = PH_DONE;
                        end
                        else
                            phase_next = (len_reg != '0) ? PH_SKIP : PH_CRC;
                    end
                    else
                        pos_next = pos_inc;
                end
                PH_HDR:
                begin
                    if (pos_reg < 32'd4)
                        width_next = {width_reg[23:0], b};
                    else if (pos_reg < 32'd8)
                        height_next = {height_reg[23:0], b};
                    else if (pos_reg == 32'd9)
                        chan_next = (((b & COLOUR_BIT) != '0) ? 3'd3 : 3'd1)
                                  + (((b & ALPHA_BIT) != '0) ? 3'd1 : 3'd0);
                    if (pos_inc >= HDR_LEN)
                    begin
                        seen_next  = 1'b1;
                        phase_next = PH_CRC;
                        pos_next   = '0;
                    end
                    else
                        pos_next = pos_inc;
                end
                PH_DATA, PH_SKIP:
                begin
                    if (phase_reg == PH_DATA)
                    begin
                        pay    = b;
                        pvalid = 1'b1;
                    end
                    if (pos_inc >= len_reg)
                    begin
                        phase_next = PH_CRC;
                        pos_next   = '0;
                    end
                    else
                        pos_next = pos_inc;
                end
                PH_CRC:
                begin
                    if (pos_reg[1:0] == 2'd3)
                    begin
                        phase_next = PH_LEN;
                        pos_next   = '0;
                        len_next   = '0;
                        kind_next  = '0;
                    end
                    else
                        pos_next = pos_inc;
                end
                default:
                begin
                end
            endcase

            if (item.last_byte && status_next == ST_BUSY)
                status_next = ST_TRUNC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIG;
            status_reg <= ST_BUSY;
            pos_reg    <= '0;
            len_reg    <= '0;
            kind_reg   <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            chan_reg   <= '0;
            seen_reg   <= 1'b0;
        end
        else if (item_fire)
        begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            kind_reg   <= kind_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            chan_reg   <= chan_next;
            seen_reg   <= seen_next;
        end
    end

    always_comb
    begin
        result.payload_byte  = pay;
        result.payload_valid = pvalid;
        result.status        = status_next;
        result.image_width   = width_next;
        result.image_height  = height_next;
        result.channel_count = chan_next;
        result.raw_size      = (status_next == ST_DONE) ? size_value : 64'd0;
    end

    assign hdr.width    = width_reg;
    assign hdr.height   = height_reg;
    assign hdr.channels = chan_reg;

endmodule

`default_nettype wire

// ===== rtl/pcsp_checker.sv =====
// port-level checks of the png chunk stream parser, bound to the top level
// depends on pcsp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pcsp_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire pcsp_pkg::out_word_t out_word
);

    import pcsp_pkg::*;

    logic pay_ok;
    logic size_ok;

    // payload only while parsing or on the truncating byte
    assign pay_ok  = out_word.status inside {ST_BUSY, ST_TRUNC};
    // a nonzero count needs completion and a sane channel count
    assign size_ok = (out_word.status == ST_DONE)
                   && (out_word.channel_count inside {[3'd1:MAX_CHANNELS]});

    // a stalled result word holds
    `PCSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

    `PCSP_ASSERT_IMPL(a_pay_status, out_valid && out_word.payload_valid, pay_ok)

    // no stray payload byte
    `PCSP_ASSERT_IMPL(a_pay_zero, out_valid && !out_word.payload_valid, out_word.payload_byte == 8'd0)

    // sample count shows only on completion
    `PCSP_ASSERT_IMPL(a_size_done, out_valid && out_word.raw_size != 64'd0, size_ok)

endmodule

bind png_chunk_stream_parser pcsp_checker u_pcsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_s.valid),
    .out_ready (out_s.ready),
    .out_word  (out_s.payload)
);

`default_nettype wire
